>>> rtl/pbb_pkg.sv
// ----------------------------------------------------------------------------
// pbb_pkg
// Shared types, codes and constants of the particle boundary binner.
// ----------------------------------------------------------------------------
package pbb_pkg;

  localparam int MAX_PARTICLES = 65536;
  localparam int NUM_REGIONS   = 8;

  localparam int POS_W    = 32;
  localparam int INDEX_W  = 16;
  localparam int REGION_W = 4;
  localparam int SIDE_W   = 3;
  localparam int COUNT_W  = 17;
  localparam int SLOT_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int RIDX_W   = $clog2(NUM_REGIONS);

  localparam int IN_TDATA_W  = 2 * POS_W + INDEX_W;
  localparam int OUT_TDATA_W = INDEX_W + REGION_W + SIDE_W + COUNT_W + SLOT_W;
  localparam int OUT_TUSER_W = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_LIMIT =
      (MAX_PARTICLES > ((1 << COUNT_W) - 1)) ? COUNT_MAX : COUNT_W'(MAX_PARTICLES);
  localparam logic [SLOT_W-1:0]  SLOT_MAX    = {SLOT_W{1'b1}};

  typedef enum logic [REGION_W-1:0] {
    REGION_XMIN      = 4'd0,
    REGION_XMAX      = 4'd1,
    REGION_YMIN      = 4'd2,
    REGION_YMAX      = 4'd3,
    REGION_XMIN_YMIN = 4'd4,
    REGION_XMAX_YMIN = 4'd5,
    REGION_XMIN_YMAX = 4'd6,
    REGION_XMAX_YMAX = 4'd7,
    REGION_INSIDE    = 4'd8
  } region_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOUND_X_LOW  = 3'd0,
    CFG_BOUND_X_HIGH = 3'd1,
    CFG_BOUND_Y_LOW  = 3'd2,
    CFG_BOUND_Y_HIGH = 3'd3,
    CFG_NEIGHBOR     = 3'd4
  } cfg_index_e;

  typedef struct packed {
    logic signed [POS_W-1:0] x_low;
    logic signed [POS_W-1:0] x_high;
    logic signed [POS_W-1:0] y_low;
    logic signed [POS_W-1:0] y_high;
    logic [NUM_REGIONS-1:0]  neighbor;
  } cfg_t;

  typedef struct packed {
    logic               room;
    logic [COUNT_W-1:0] prior;
    logic [COUNT_W-1:0] after;
  } count_info_t;

  function automatic logic [SIDE_W-1:0] opposite_side(input logic [RIDX_W-1:0] r);
    logic [SIDE_W-1:0] s;
    case (r)
      3'd0:    s = 3'd1;
      3'd1:    s = 3'd0;
      3'd2:    s = 3'd3;
      3'd3:    s = 3'd2;
      3'd4:    s = 3'd7;
      3'd5:    s = 3'd6;
      3'd6:    s = 3'd5;
      default: s = 3'd4;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/pbb_cfg_regs.sv
// ----------------------------------------------------------------------------
// pbb_cfg_regs
// Bound and neighbor registers written through the configuration channel.
// ----------------------------------------------------------------------------
module pbb_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [pbb_pkg::CFG_IDX_W-1:0]   wr_index_i,
  input  logic [pbb_pkg::CFG_DATA_W-1:0]  wr_data_i,
  output pbb_pkg::cfg_t                   cfg_o
);

  pbb_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en_i) begin
      case (wr_index_i)
        pbb_pkg::CFG_BOUND_X_LOW:  cfg_q.x_low  <= $signed(wr_data_i);
        pbb_pkg::CFG_BOUND_X_HIGH: cfg_q.x_high <= $signed(wr_data_i);
        pbb_pkg::CFG_BOUND_Y_LOW:  cfg_q.y_low  <= $signed(wr_data_i);
        pbb_pkg::CFG_BOUND_Y_HIGH: cfg_q.y_high <= $signed(wr_data_i);
        pbb_pkg::CFG_NEIGHBOR:     cfg_q.neighbor <= wr_data_i[pbb_pkg::NUM_REGIONS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/pbb_classifier.sv
// ----------------------------------------------------------------------------
// pbb_classifier
// Strict bound tests of one particle, y first, giving its exit region.
// ----------------------------------------------------------------------------
module pbb_classifier (
  input  logic signed [pbb_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [pbb_pkg::POS_W-1:0] pos_y_i,
  input  logic                             is_dead_i,
  input  pbb_pkg::cfg_t                    cfg_i,
  output pbb_pkg::region_e                 region_o
);

  logic x_lt, x_gt, y_lt, y_gt;

  assign x_lt = pos_x_i < cfg_i.x_low;
  assign x_gt = pos_x_i > cfg_i.x_high;
  assign y_lt = pos_y_i < cfg_i.y_low;
  assign y_gt = pos_y_i > cfg_i.y_high;

  always_comb begin
    if (is_dead_i) begin
      region_o = pbb_pkg::REGION_INSIDE;
    end else if (y_lt) begin
      region_o = x_lt ? pbb_pkg::REGION_XMIN_YMIN :
                 x_gt ? pbb_pkg::REGION_XMAX_YMIN : pbb_pkg::REGION_YMIN;
    end else if (y_gt) begin
      region_o = x_lt ? pbb_pkg::REGION_XMIN_YMAX :
                 x_gt ? pbb_pkg::REGION_XMAX_YMAX : pbb_pkg::REGION_YMAX;
    end else begin
      region_o = x_lt ? pbb_pkg::REGION_XMIN :
                 x_gt ? pbb_pkg::REGION_XMAX : pbb_pkg::REGION_INSIDE;
    end
  end

endmodule

>>> rtl/pbb_region_counters.sv
// ----------------------------------------------------------------------------
// pbb_region_counters
// Saturating per-region counters, cleared after the last particle of a frame.
// ----------------------------------------------------------------------------
module pbb_region_counters (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 update_i,
  input  pbb_pkg::region_e     region_i,
  input  logic                 frame_end_i,
  output pbb_pkg::count_info_t info_o
);

  logic [pbb_pkg::COUNT_W-1:0] count_q [pbb_pkg::NUM_REGIONS];
  logic [pbb_pkg::RIDX_W-1:0]  ridx;
  logic                        hit;

  assign ridx = region_i[pbb_pkg::RIDX_W-1:0];
  assign hit  = region_i != pbb_pkg::REGION_INSIDE;

  always_comb begin
    info_o.prior = count_q[ridx];
    info_o.room  = info_o.prior < pbb_pkg::COUNT_LIMIT;
    info_o.after = info_o.room ? info_o.prior + 1'b1 : info_o.prior;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < pbb_pkg::NUM_REGIONS; r++) count_q[r] <= '0;
    end else if (update_i) begin
      if (frame_end_i) begin
        for (int r = 0; r < pbb_pkg::NUM_REGIONS; r++) count_q[r] <= '0;
      end else if (hit) begin
        count_q[ridx] <= info_o.after;
      end
    end
  end

endmodule

>>> rtl/particle_boundary_binner_unit.sv
// ----------------------------------------------------------------------------
// particle_boundary_binner_unit
// Bins a stream of particles into patch exit regions with per-region counts.
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  particle: pos_x, pos_y, index,
//                                             tuser is_dead, tlast frame end
// m_axis    out  m_axis_tvalid/m_axis_tready  region, side, counts, flags
// cfg       in   cfg_valid_i/cfg_ready_o      register index and write data
//
// One particle per cycle sustained while m_axis_tready is high; an input
// transaction passes the input register, then the result register.
// The classify compares and the counter increment sit between the two
// registers. Reset clears the bounds, neighbor mask and all counters.
// A stalled result holds; the input register takes one more transaction
// and holds it, then s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module particle_boundary_binner_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pos_x [31:0], pos_y [63:32], particle_index [79:64]
  input  logic [pbb_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // is_dead [0]
  input  logic                                s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // index_out [15:0], region [19:16], dest_side [22:20],
  // region_count [39:23], slot_index [55:40]
  output logic [pbb_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // routed [0], kill [1]
  output logic [pbb_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
  output logic                                m_axis_tlast,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pbb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pbb_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int PW = pbb_pkg::POS_W;

  pbb_pkg::cfg_t        cfg;
  pbb_pkg::region_e     region;
  pbb_pkg::count_info_t info;

  logic                            in_valid_q;
  logic signed [PW-1:0]            pos_x_q, pos_y_q;
  logic [pbb_pkg::INDEX_W-1:0]     index_q;
  logic                            dead_q, last_q;

  logic                            out_valid_q;
  logic [pbb_pkg::INDEX_W-1:0]     index_out_q;
  logic [pbb_pkg::REGION_W-1:0]    region_q;
  logic [pbb_pkg::SIDE_W-1:0]      side_q, side_d;
  logic [pbb_pkg::COUNT_W-1:0]     count_q, count_d;
  logic [pbb_pkg::SLOT_W-1:0]      slot_q, slot_d;
  logic                            routed_q, routed_d;
  logic                            kill_q, kill_d;
  logic                            frame_end_q;

  logic advance, in_fire, leaving;
  logic [pbb_pkg::RIDX_W-1:0] ridx;

  assign cfg_ready_o   = 1'b1;
  assign advance       = !out_valid_q || m_axis_tready;
  assign in_fire       = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  pbb_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pos_x_q <= $signed(s_axis_tdata[PW-1:0]);
      pos_y_q <= $signed(s_axis_tdata[2*PW-1:PW]);
      index_q <= s_axis_tdata[2*PW +: pbb_pkg::INDEX_W];
      dead_q  <= s_axis_tuser;
      last_q  <= s_axis_tlast;
    end
  end

  pbb_classifier u_classify (
    .pos_x_i   (pos_x_q),
    .pos_y_i   (pos_y_q),
    .is_dead_i (dead_q),
    .cfg_i     (cfg),
    .region_o  (region)
  );

  pbb_region_counters u_counters (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .update_i    (in_fire),
    .region_i    (region),
    .frame_end_i (last_q),
    .info_o      (info)
  );

  assign ridx    = region[pbb_pkg::RIDX_W-1:0];
  assign leaving = region != pbb_pkg::REGION_INSIDE;

  always_comb begin
    side_d   = '0;
    count_d  = '0;
    slot_d   = '0;
    routed_d = 1'b0;
    kill_d   = 1'b0;
    if (leaving) begin
      side_d   = pbb_pkg::opposite_side(ridx);
      count_d  = info.after;
      slot_d   = (info.prior > pbb_pkg::COUNT_W'(pbb_pkg::SLOT_MAX)) ?
                 pbb_pkg::SLOT_MAX : info.prior[pbb_pkg::SLOT_W-1:0];
      routed_d = cfg.neighbor[ridx] && info.room;
      kill_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      index_out_q <= index_q;
      region_q    <= region;
      side_q      <= side_d;
      count_q     <= count_d;
      slot_q      <= slot_d;
      routed_q    <= routed_d;
      kill_q      <= kill_d;
      frame_end_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {slot_q, count_q, side_q, region_q, index_out_q};
  assign m_axis_tuser  = {kill_q, routed_q};
  assign m_axis_tlast  = frame_end_q;

endmodule

>>> dv/exit_region_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// exit_region_checker
// Watches the particle, result and register channels of the boundary binner.
// Keeps its own copy of the bounds, neighbor mask and per-region tallies,
// predicts the result of every accepted particle and compares each accepted
// result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module exit_region_checker
  import pbb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input  logic                   m_axis_tlast,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     mismatch_count_o,
  output int                     outstanding_o,
  output int                     particles_o,
  output int                     frames_o,
  output int                     kills_o,
  output int                     routed_o,
  output int                     full_hits_o
);

  localparam int Y_LSB      = POS_W;
  localparam int INDEX_LSB  = 2 * POS_W;
  localparam int REGION_LSB = INDEX_W;
  localparam int SIDE_LSB   = REGION_LSB + REGION_W;
  localparam int COUNT_LSB  = SIDE_LSB + SIDE_W;
  localparam int SLOT_LSB   = COUNT_LSB + COUNT_W;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    region_e            region;
    logic [SIDE_W-1:0]  side;
    logic [COUNT_W-1:0] count;
    logic [SLOT_W-1:0]  slot;
    logic               routed;
    logic               kill;
    logic               frame_end;
  } bin_result_t;

  cfg_t               bounds;
  logic [COUNT_W-1:0] region_tally [NUM_REGIONS];
  bin_result_t        pending_bins [$];

  function automatic region_e locate_exit(input logic signed [POS_W-1:0] x,
                                          input logic signed [POS_W-1:0] y);
    logic below_x;
    logic above_x;
    below_x = x < $signed(bounds.x_low);
    above_x = x > $signed(bounds.x_high);
    if (y < $signed(bounds.y_low)) begin
      if (below_x) return REGION_XMIN_YMIN;
      if (above_x) return REGION_XMAX_YMIN;
      return REGION_YMIN;
    end
    if (y > $signed(bounds.y_high)) begin
      if (below_x) return REGION_XMIN_YMAX;
      if (above_x) return REGION_XMAX_YMAX;
      return REGION_YMAX;
    end
    if (below_x) return REGION_XMIN;
    if (above_x) return REGION_XMAX;
    return REGION_INSIDE;
  endfunction

  function automatic logic [SIDE_W-1:0] facing_side(input region_e r);
    region_e f;
    case (r)
      REGION_XMIN:      f = REGION_XMAX;
      REGION_XMAX:      f = REGION_XMIN;
      REGION_YMIN:      f = REGION_YMAX;
      REGION_YMAX:      f = REGION_YMIN;
      REGION_XMIN_YMIN: f = REGION_XMAX_YMAX;
      REGION_XMAX_YMIN: f = REGION_XMIN_YMAX;
      REGION_XMIN_YMAX: f = REGION_XMAX_YMIN;
      default:          f = REGION_XMIN_YMIN;
    endcase
    return f[SIDE_W-1:0];
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bin_result_t        got;
    bin_result_t        want;
    bin_result_t        fresh;
    logic [COUNT_W-1:0] prior;
    logic               room;
    logic [RIDX_W-1:0]  slot_of;
    if (!rst_ni) begin
      bounds = '0;
      for (int r = 0; r < NUM_REGIONS; r++) region_tally[r] = '0;
      pending_bins.delete();
      mismatch_count_o = 0;
      outstanding_o    = 0;
      particles_o      = 0;
      frames_o         = 0;
      kills_o          = 0;
      routed_o         = 0;
      full_hits_o      = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.index     = m_axis_tdata[INDEX_W-1:0];
        got.region    = region_e'(m_axis_tdata[REGION_LSB +: REGION_W]);
        got.side      = m_axis_tdata[SIDE_LSB +: SIDE_W];
        got.count     = m_axis_tdata[COUNT_LSB +: COUNT_W];
        got.slot      = m_axis_tdata[SLOT_LSB +: SLOT_W];
        got.routed    = m_axis_tuser[0];
        got.kill      = m_axis_tuser[1];
        got.frame_end = m_axis_tlast;
        if (pending_bins.size() == 0) begin
          $error("unexpected result transaction, index_out %0d", got.index);
          mismatch_count_o++;
        end else begin
          want = pending_bins.pop_front();
          check_field("index_out", want.index, got.index);
          check_field("region", want.region, got.region);
          check_field("dest_side", want.side, got.side);
          check_field("region_count", want.count, got.count);
          check_field("slot_index", want.slot, got.slot);
          check_field("routed", want.routed, got.routed);
          check_field("kill", want.kill, got.kill);
          check_field("frame_end", want.frame_end, got.frame_end);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        fresh           = '0;
        fresh.index     = s_axis_tdata[INDEX_LSB +: INDEX_W];
        fresh.frame_end = s_axis_tlast;
        fresh.region    = s_axis_tuser ? REGION_INSIDE :
            locate_exit(s_axis_tdata[POS_W-1:0], s_axis_tdata[Y_LSB +: POS_W]);
        if (fresh.region != REGION_INSIDE) begin
          slot_of     = fresh.region[RIDX_W-1:0];
          prior       = region_tally[slot_of];
          room        = prior < COUNT_LIMIT;
          fresh.count = room ? prior + 1'b1 : prior;
          region_tally[slot_of] = fresh.count;
          fresh.side   = facing_side(fresh.region);
          fresh.slot   = (prior > COUNT_W'(SLOT_MAX)) ? SLOT_MAX : prior[SLOT_W-1:0];
          fresh.routed = bounds.neighbor[slot_of] && room;
          fresh.kill   = 1'b1;
          kills_o++;
          if (fresh.routed) routed_o++;
          if (!room) full_hits_o++;
        end
        if (s_axis_tlast) begin
          for (int r = 0; r < NUM_REGIONS; r++) region_tally[r] = '0;
          frames_o++;
        end
        pending_bins.push_back(fresh);
        particles_o++;
      end

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_BOUND_X_LOW:  bounds.x_low    = cfg_data_i;
          CFG_BOUND_X_HIGH: bounds.x_high   = cfg_data_i;
          CFG_BOUND_Y_LOW:  bounds.y_low    = cfg_data_i;
          CFG_BOUND_Y_HIGH: bounds.y_high   = cfg_data_i;
          CFG_NEIGHBOR:     bounds.neighbor = cfg_data_i[NUM_REGIONS-1:0];
          default: ;
        endcase
      end

      outstanding_o = pending_bins.size();
    end
  end

endmodule

>>> dv/particle_boundary_binner_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// particle_boundary_binner_unit_tb
// Drives particles and register writes into the boundary binner with bursty
// input and a stalling output, while the exit region checker predicts and
// compares every result. Covers directed edge cases and random phases over
// many bound settings, frame lengths and neighbor masks.
// ----------------------------------------------------------------------------
module particle_boundary_binner_unit_tb;
  import pbb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 146;

  localparam logic [CFG_IDX_W-1:0]   CFG_SPARE_LO = 3'd5;
  localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] EDGE_X  = 32'sd6553600;
  localparam logic signed [POS_W-1:0] EDGE_Y  = 32'sd3276800;
  localparam logic [INDEX_W-1:0]      IDX_TOP = {INDEX_W{1'b1}};

  typedef enum int {
    BOUNDS_SPREAD,
    BOUNDS_OPEN,
    BOUNDS_CROSSED,
    BOUNDS_ZERO,
    BOUNDS_POINT,
    BOUNDS_SHUT,
    BOUNDS_KINDS
  } bounds_kind_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  int mismatches;
  int outstanding;
  int particles;
  int frames;
  int kills;
  int routed;
  int full_hits;

  int burst_left  = 0;
  int idle_cycles = 0;
  int stall_left  = 0;
  int rx_mode     = 0;
  int mode_left   = 0;

  logic signed [POS_W-1:0] cur_xl;
  logic signed [POS_W-1:0] cur_xh;
  logic signed [POS_W-1:0] cur_yl;
  logic signed [POS_W-1:0] cur_yh;

  initial forever #1 clk_i = ~clk_i;

  particle_boundary_binner_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  exit_region_checker u_exit_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .s_axis_tlast     (s_axis_tlast),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .m_axis_tlast     (m_axis_tlast),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding),
    .particles_o      (particles),
    .frames_o         (frames),
    .kills_o          (kills),
    .routed_o         (routed),
    .full_hits_o      (full_hits)
  );

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      rx_mode   <= $urandom_range(0, 2);
      mode_left <= $urandom_range(50, 400);
    end else begin
      mode_left <= mode_left - 1;
    end
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (rx_mode == 1 && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 3);
    end else if (rx_mode == 2 && $urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 24);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic load_config(input logic signed [POS_W-1:0] xl, input logic signed [POS_W-1:0] xh,
                             input logic signed [POS_W-1:0] yl, input logic signed [POS_W-1:0] yh,
                             input logic [NUM_REGIONS-1:0] mask, input bit spare);
    cur_xl = xl;
    cur_xh = xh;
    cur_yl = yl;
    cur_yh = yh;
    put_reg(CFG_BOUND_X_LOW, xl);
    put_reg(CFG_BOUND_X_HIGH, xh);
    put_reg(CFG_BOUND_Y_LOW, yl);
    put_reg(CFG_BOUND_Y_HIGH, yh);
    put_reg(CFG_NEIGHBOR, {24'($urandom), mask});
    // unmapped index: must not touch any register
    if (spare) put_reg(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 2)), $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_particle(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                               input logic dead, input logic [INDEX_W-1:0] idx,
                               input logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) :
                                                 $urandom_range(1, 40);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {idx, y, x};
    s_axis_tuser  <= dead;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic signed [POS_W-1:0] pick_coord(input logic signed [POS_W-1:0] lo,
                                                         input logic signed [POS_W-1:0] hi);
    longint span;
    span = longint'(hi) - longint'(lo) + 1;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return lo - 1;
      2: return lo;
      3: return lo + 1;
      4: return hi - 1;
      5: return hi;
      6: return hi + 1;
      7: return POS_MIN;
      8: return POS_MAX;
      default: begin
        if (span <= 1) return $urandom;
        return POS_W'(longint'(lo) + longint'({$urandom, $urandom} % span));
      end
    endcase
  endfunction

  task automatic pick_pair(input bounds_kind_e kind, output logic signed [POS_W-1:0] lo,
                           output logic signed [POS_W-1:0] hi);
    logic signed [POS_W-1:0] a;
    logic signed [POS_W-1:0] b;
    a = $urandom;
    b = $urandom;
    case (kind)
      BOUNDS_SPREAD:  begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
      BOUNDS_OPEN:    begin lo = POS_MIN; hi = POS_MAX; end
      BOUNDS_CROSSED: begin lo = (a < b) ? b : a; hi = (a < b) ? a : b; end
      BOUNDS_ZERO:    begin lo = '0; hi = '0; end
      BOUNDS_POINT:   begin lo = a; hi = a; end
      default:        begin lo = POS_MAX; hi = POS_MIN; end
    endcase
  endtask

  task automatic send_random(input logic last);
    send_particle(pick_coord(cur_xl, cur_xh), pick_coord(cur_yl, cur_yh),
                  $urandom_range(0, 9) == 0, INDEX_W'($urandom), last);
  endtask

  initial begin
    logic signed [POS_W-1:0] xl;
    logic signed [POS_W-1:0] xh;
    logic signed [POS_W-1:0] yl;
    logic signed [POS_W-1:0] yh;
    logic [NUM_REGIONS-1:0]  mask;
    int frame_left;

    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_BOUND_X_LOW;
    cfg_data_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers still at reset: all bounds zero, no neighbors
    send_particle('0, '0, 1'b0, '0, 1'b0);
    send_particle(32'sd1, '0, 1'b0, 16'd1, 1'b0);
    send_particle(-32'sd1, -32'sd1, 1'b0, 16'd2, 1'b1);
    settle();

    load_config(-EDGE_X, EDGE_X, -EDGE_Y, EDGE_Y, 8'b0101_0101, 1'b1);
    send_particle('0, '0, 1'b0, '0, 1'b0);
    send_particle(-EDGE_X, '0, 1'b0, 16'd3, 1'b0);
    send_particle(-EDGE_X - 1, '0, 1'b0, IDX_TOP, 1'b0);
    send_particle(EDGE_X + 1, '0, 1'b0, 16'd4, 1'b0);
    send_particle('0, -EDGE_Y - 1, 1'b0, 16'd5, 1'b0);
    send_particle('0, EDGE_Y + 1, 1'b0, 16'd6, 1'b0);
    send_particle(-EDGE_X - 1, -EDGE_Y - 1, 1'b0, 16'd7, 1'b0);
    send_particle(EDGE_X + 1, -EDGE_Y - 1, 1'b0, 16'd8, 1'b0);
    send_particle(-EDGE_X - 1, EDGE_Y + 1, 1'b0, 16'd9, 1'b0);
    send_particle(EDGE_X + 1, EDGE_Y + 1, 1'b0, 16'd10, 1'b0);
    send_particle(POS_MIN, POS_MIN, 1'b0, 16'd11, 1'b0);
    send_particle(POS_MAX, POS_MAX, 1'b0, 16'd12, 1'b0);
    send_particle(POS_MAX, POS_MAX, 1'b1, 16'd13, 1'b0);
    send_particle(EDGE_X, EDGE_Y, 1'b0, 16'd14, 1'b0);
    send_particle(POS_MIN, '0, 1'b0, 16'd15, 1'b1);
    send_particle(POS_MIN, '0, 1'b0, 16'd16, 1'b0);
    send_particle(POS_MIN, POS_MAX, 1'b1, 16'd17, 1'b1);
    settle();

    load_config(EDGE_X, -EDGE_X, EDGE_Y, -EDGE_Y, 8'hFF, 1'b0);
    send_particle('0, '0, 1'b0, 16'd18, 1'b0);
    send_particle(EDGE_X + EDGE_X, '0, 1'b0, 16'd19, 1'b1);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_pair(bounds_kind_e'(phase % BOUNDS_KINDS), xl, xh);
      pick_pair(bounds_kind_e'($urandom_range(0, BOUNDS_KINDS - 1)), yl, yh);
      case ($urandom_range(0, 3))
        0:       mask = '0;
        1:       mask = '1;
        default: mask = $urandom;
      endcase
      load_config(xl, xh, yl, yh, mask, $urandom_range(0, 2) == 0);
      frame_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (frame_left == 0)
          frame_left = ($urandom_range(0, 5) == 0) ? $urandom_range(41, 300) :
                                                     $urandom_range(1, 40);
        frame_left--;
        send_random(frame_left == 0);
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    $display("Ran %0d particles in %0d frames over %0d bound settings plus directed cases.",
             particles, frames, RANDOM_PHASES + 3);
    $display("Exits: %0d killed, %0d routed, %0d met a saturated counter.",
             kills, routed, full_hits);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pbb_pkg.sv
rtl/pbb_cfg_regs.sv
rtl/pbb_classifier.sv
rtl/pbb_region_counters.sv
rtl/particle_boundary_binner_unit.sv
dv/exit_region_checker.sv
dv/particle_boundary_binner_unit_tb.sv
